### hw/rtl/sws_pkg.sv
// ----------------------------------------------------------------------------
// sws_pkg
// shared constants, operation codes and the command type of the statistics unit
// ----------------------------------------------------------------------------
package sws_pkg;

  localparam int WINDOW_DEPTH = 64;
  localparam int SAMPLE_BITS  = 24;

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int SUM_W  = SAMPLE_BITS + IDX_W;
  localparam int SQS_W  = 2 * SAMPLE_BITS + IDX_W;
  localparam int A_W    = SQS_W + CNT_W;
  localparam int B_W    = 2 * SUM_W;
  localparam int DIV_W  = A_W;
  localparam int NN_W   = 2 * CNT_W;
  localparam int DCNT_W = $clog2(DIV_W);
  localparam int VAR_W  = 2 * SAMPLE_BITS;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_ADD   = 2'd1,
    OP_APPLY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // one classified item: push a value into the window or only report
  typedef struct packed {
    logic                   do_push;
    logic [SAMPLE_BITS-1:0] value;
  } cmd_t;

endpackage

### hw/rtl/sliding_window_statistics_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_statistics_unit
// count, floor mean, integer stddev, min and max over a ring window of samples
// ----------------------------------------------------------------------------
//
// channel  direction  handshake             payload
// in_      input      in_valid / in_stall   in_operation, in_sample
// out_     output     out_valid / out_stall window count, mean, std dev, min, max, has_data
//
// one result per input transfer; from pop to result register the back sequencer
// runs the statistics for a report-only item, first a window update for a push
// and also an eviction for a push that evicts: one bit per cycle through the
// shared restoring divider (30 steps for the mean, 61 for the variance), one
// result bit per cycle of square root (24 steps), plus a window rescan when an
// evicted sample was the minimum or maximum; an empty window skips divider and
// square root. reset is synchronous; the window store needs no clear.
// the front takes items while the two-entry queue has room, the output
// register holds a stalled result while the back works on the next item
//
module sliding_window_statistics_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_operation,
  input  logic [sws_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sws_pkg::CNT_W-1:0]       out_window_count,
  output logic [sws_pkg::SAMPLE_BITS-1:0] out_mean,
  output logic [sws_pkg::SAMPLE_BITS-1:0] out_std_dev,
  output logic [sws_pkg::SAMPLE_BITS-1:0] out_min_value,
  output logic [sws_pkg::SAMPLE_BITS-1:0] out_max_value,
  output logic                            out_has_data
);
  import sws_pkg::*;

  // front side of the queue
  cmd_t front_cmd;
  logic q_full;
  logic in_xfer;

  // back side of the queue
  cmd_t back_cmd;
  logic q_avail;
  logic q_pop;

  // an input transfer happens when in_valid is high and the queue has room
  assign in_stall = q_full;
  assign in_xfer  = in_valid & ~q_full;

  // classify: push, pending add, pending apply, or report only
  sws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_xfer),
    .operation (in_operation),
    .sample    (in_sample),
    .cmd       (front_cmd)
  );

  // decouples classification from the long statistics sequence
  sws_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_avail),
    .pop_cmd   (back_cmd)
  );

  // window update, rescan, divide, square root and result register
  sws_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_avail        (q_avail),
    .cmd              (back_cmd),
    .cmd_pop          (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_window_count (out_window_count),
    .out_mean         (out_mean),
    .out_std_dev      (out_std_dev),
    .out_min_value    (out_min_value),
    .out_max_value    (out_max_value),
    .out_has_data     (out_has_data)
  );

endmodule

### hw/rtl/sws_front.sv
// ----------------------------------------------------------------------------
// sws_front
// classifies input items and keeps the saturating pending total
// ----------------------------------------------------------------------------
module sws_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            accept,
  input  logic [1:0]                      operation,
  input  logic [sws_pkg::SAMPLE_BITS-1:0] sample,
  output sws_pkg::cmd_t                   cmd
);
  import sws_pkg::*;

  logic [SAMPLE_BITS-1:0] pend_r, pend_nxt;
  logic                   flag_r, flag_nxt;
  logic [SAMPLE_BITS:0]   pend_sum;

  assign pend_sum = {1'b0, pend_r} + {1'b0, sample};

  always_comb begin
    pend_nxt    = pend_r;
    flag_nxt    = flag_r;
    cmd.do_push = 1'b0;
    cmd.value   = sample;
    case (op_t'(operation))
      OP_PUSH: begin
        cmd.do_push = 1'b1;
      end
      OP_ADD: begin
        pend_nxt = pend_sum[SAMPLE_BITS] ? {SAMPLE_BITS{1'b1}} : pend_sum[SAMPLE_BITS-1:0];
        flag_nxt = 1'b1;
      end
      OP_APPLY: begin
        cmd.value = pend_r;
        if (flag_r) begin
          cmd.do_push = 1'b1;
          pend_nxt    = '0;
          flag_nxt    = 1'b0;
        end
      end
      default: begin
        cmd.do_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      flag_r <= 1'b0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      flag_r <= flag_nxt;
    end
  end

endmodule

### hw/rtl/sws_queue.sv
// ----------------------------------------------------------------------------
// sws_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module sws_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sws_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output sws_pkg::cmd_t pop_cmd
);
  import sws_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_cmd   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### hw/rtl/sws_back.sv
// ----------------------------------------------------------------------------
// sws_back
// window store, running sums, rescan, divider and square root sequencer
// ----------------------------------------------------------------------------
module sws_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_avail,
  input  sws_pkg::cmd_t                   cmd,
  output logic                            cmd_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sws_pkg::CNT_W-1:0]       out_window_count,
  output logic [sws_pkg::SAMPLE_BITS-1:0] out_mean,
  output logic [sws_pkg::SAMPLE_BITS-1:0] out_std_dev,
  output logic [sws_pkg::SAMPLE_BITS-1:0] out_min_value,
  output logic [sws_pkg::SAMPLE_BITS-1:0] out_max_value,
  output logic                            out_has_data
);
  import sws_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RD    = 13'b0000000000010,
    S_UPD   = 13'b0000000000100,
    S_EVSQ  = 13'b0000000001000,
    S_EVSUB = 13'b0000000010000,
    S_SCAN  = 13'b0000000100000,
    S_STAT  = 13'b0000001000000,
    S_SQB   = 13'b0000010000000,
    S_NN    = 13'b0000100000000,
    S_DIVM  = 13'b0001000000000,
    S_DIVV  = 13'b0010000000000,
    S_SQRT  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(WINDOW_DEPTH);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [DCNT_W-1:0] MEAN_END = DCNT_W'(SUM_W - 1);
  localparam logic [DCNT_W-1:0] VAR_END  = DCNT_W'(DIV_W - 1);

  state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] mem [WINDOW_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_r;
  logic [IDX_W-1:0]       mem_ra, mem_wa;
  logic                   mem_we;

  logic [CNT_W-1:0]       fill_r, fill_nxt;
  logic [IDX_W-1:0]       oldest_r, oldest_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [SQS_W-1:0]       sumsq_r, sumsq_nxt;
  logic [SAMPLE_BITS-1:0] min_r, min_nxt, max_r, max_nxt;
  logic [SAMPLE_BITS-1:0] cur_v_r, cur_v_nxt, old_r, old_nxt;
  logic                   push_r, push_nxt;
  logic [A_W-1:0]         prod_r, prod_nxt, a_r, a_nxt, diff_r, diff_nxt;
  logic [NN_W-1:0]        nn_r, nn_nxt;
  logic [SAMPLE_BITS-1:0] mean_r, mean_nxt;
  logic [DIV_W-1:0]       div_sh_r, div_sh_nxt;
  logic [NN_W-1:0]        div_rem_r, div_rem_nxt, div_dv_r, div_dv_nxt;
  logic [DCNT_W-1:0]      div_cnt_r, div_cnt_nxt;
  logic [VAR_W-1:0]       sq_v_r, sq_v_nxt, sq_res_r, sq_res_nxt, sq_bit_r, sq_bit_nxt;
  logic [CNT_W-1:0]       scan_idx_r, scan_idx_nxt;
  logic                   scan_vld_r, scan_vld_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   load_out;

  // shared arithmetic
  logic [SAMPLE_BITS-1:0] sq_in;
  logic [VAR_W-1:0]       sq_p;
  logic [A_W-1:0]         na_p;
  logic [B_W-1:0]         bb_p;
  logic [NN_W:0]          div_t;
  logic                   div_ge;
  logic [NN_W:0]          div_t_sub;
  logic [VAR_W-1:0]       sq_rb;
  logic                   full;

  assign sq_in = (state_r == S_EVSQ) ? old_r : cur_v_r;
  assign sq_p  = VAR_W'(sq_in) * VAR_W'(sq_in);
  assign na_p  = A_W'(fill_r) * A_W'(sumsq_r);
  assign bb_p  = B_W'(sum_r) * B_W'(sum_r);

  assign div_t     = {div_rem_r, div_sh_r[DIV_W-1]};
  assign div_ge    = (div_t >= {1'b0, div_dv_r});
  assign div_t_sub = div_t - {1'b0, div_dv_r};
  assign sq_rb     = sq_res_r + sq_bit_r;
  assign full      = (fill_r >= DEPTH_C);

  assign mem_ra = (state_r == S_SCAN) ? scan_idx_r[IDX_W-1:0] : oldest_r;
  assign mem_wa = full ? oldest_r : fill_r[IDX_W-1:0];
  assign mem_we = (state_r == S_UPD);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= cur_v_r;
    end
    rdata_r <= mem[mem_ra];
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    oldest_nxt    = oldest_r;
    sum_nxt       = sum_r;
    sumsq_nxt     = sumsq_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    cur_v_nxt     = cur_v_r;
    old_nxt       = old_r;
    push_nxt      = push_r;
    prod_nxt      = prod_r;
    a_nxt         = a_r;
    diff_nxt      = diff_r;
    nn_nxt        = nn_r;
    mean_nxt      = mean_r;
    div_sh_nxt    = div_sh_r;
    div_rem_nxt   = div_rem_r;
    div_dv_nxt    = div_dv_r;
    div_cnt_nxt   = div_cnt_r;
    sq_v_nxt      = sq_v_r;
    sq_res_nxt    = sq_res_r;
    sq_bit_nxt    = sq_bit_r;
    scan_idx_nxt  = scan_idx_r;
    scan_vld_nxt  = scan_vld_r;
    cmd_pop       = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r & out_stall;

    case (state_r)
      S_IDLE: begin
        if (cmd_avail) begin
          cmd_pop   = 1'b1;
          cur_v_nxt = cmd.value;
          push_nxt  = cmd.do_push;
          state_nxt = cmd.do_push ? S_RD : S_STAT;
        end
      end
      S_RD: begin
        // oldest entry read is issued here, new square formed
        prod_nxt  = A_W'(sq_p);
        state_nxt = S_UPD;
      end
      S_UPD: begin
        sumsq_nxt = sumsq_r + SQS_W'(prod_r);
        sum_nxt   = sum_r + SUM_W'(cur_v_r);
        if (full) begin
          old_nxt    = rdata_r;
          oldest_nxt = (oldest_r == LAST_IDX) ? '0 : oldest_r + 1'b1;
          state_nxt  = S_EVSQ;
        end else begin
          fill_nxt  = fill_r + 1'b1;
          if (cur_v_r < min_r) min_nxt = cur_v_r;
          if (cur_v_r > max_r) max_nxt = cur_v_r;
          state_nxt = S_STAT;
        end
      end
      S_EVSQ: begin
        prod_nxt  = A_W'(sq_p);
        sum_nxt   = sum_r - SUM_W'(old_r);
        state_nxt = S_EVSUB;
      end
      S_EVSUB: begin
        sumsq_nxt = sumsq_r - SQS_W'(prod_r);
        if (old_r == min_r || old_r == max_r) begin
          min_nxt      = '1;
          max_nxt      = '0;
          scan_idx_nxt = '0;
          scan_vld_nxt = 1'b0;
          state_nxt    = S_SCAN;
        end else begin
          if (cur_v_r < min_r) min_nxt = cur_v_r;
          if (cur_v_r > max_r) max_nxt = cur_v_r;
          state_nxt = S_STAT;
        end
      end
      S_SCAN: begin
        // read issue and compare overlap; scan_vld_r marks registered read data to compare
        if (scan_vld_r) begin
          if (rdata_r < min_r) min_nxt = rdata_r;
          if (rdata_r > max_r) max_nxt = rdata_r;
        end
        if (scan_idx_r < fill_r) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
          scan_vld_nxt = 1'b1;
        end else begin
          scan_vld_nxt = 1'b0;
          if (!scan_vld_r) state_nxt = S_STAT;
        end
      end
      S_STAT: begin
        if (fill_r == '0) begin
          mean_nxt   = '0;
          sq_res_nxt = '0;
          state_nxt  = S_DONE;
        end else begin
          prod_nxt  = na_p;
          state_nxt = S_SQB;
        end
      end
      S_SQB: begin
        a_nxt     = prod_r;
        prod_nxt  = A_W'(bb_p);
        state_nxt = S_NN;
      end
      S_NN: begin
        diff_nxt    = (a_r > prod_r) ? a_r - prod_r : '0;
        nn_nxt      = NN_W'(fill_r) * NN_W'(fill_r);
        div_sh_nxt  = {sum_r, {(DIV_W - SUM_W){1'b0}}};
        div_rem_nxt = '0;
        div_dv_nxt  = NN_W'(fill_r);
        div_cnt_nxt = '0;
        state_nxt   = S_DIVM;
      end
      S_DIVM, S_DIVV: begin
        div_sh_nxt  = {div_sh_r[DIV_W-2:0], div_ge};
        div_rem_nxt = div_ge ? div_t_sub[NN_W-1:0] : div_t[NN_W-1:0];
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (state_r == S_DIVM && div_cnt_r == MEAN_END) begin
          mean_nxt    = SAMPLE_BITS'(div_sh_nxt[SUM_W-1:0]);
          div_sh_nxt  = diff_r;
          div_rem_nxt = '0;
          div_dv_nxt  = nn_r;
          div_cnt_nxt = '0;
          state_nxt   = S_DIVV;
        end else if (state_r == S_DIVV && div_cnt_r == VAR_END) begin
          sq_v_nxt   = div_sh_nxt[VAR_W-1:0];
          sq_res_nxt = '0;
          sq_bit_nxt = VAR_W'(1) << (VAR_W - 2);
          state_nxt  = S_SQRT;
        end
      end
      S_SQRT: begin
        if (sq_v_r >= sq_rb) begin
          sq_v_nxt   = sq_v_r - sq_rb;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
        if (sq_bit_r[0]) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      oldest_r    <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      min_r       <= '1;
      max_r       <= '0;
      scan_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      oldest_r    <= oldest_nxt;
      sum_r       <= sum_nxt;
      sumsq_r     <= sumsq_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      scan_vld_r  <= scan_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_v_r    <= cur_v_nxt;
    old_r      <= old_nxt;
    push_r     <= push_nxt;
    prod_r     <= prod_nxt;
    a_r        <= a_nxt;
    diff_r     <= diff_nxt;
    nn_r       <= nn_nxt;
    mean_r     <= mean_nxt;
    div_sh_r   <= div_sh_nxt;
    div_rem_r  <= div_rem_nxt;
    div_dv_r   <= div_dv_nxt;
    div_cnt_r  <= div_cnt_nxt;
    sq_v_r     <= sq_v_nxt;
    sq_res_r   <= sq_res_nxt;
    sq_bit_r   <= sq_bit_nxt;
    scan_idx_r <= scan_idx_nxt;
    if (load_out) begin
      out_window_count <= fill_r;
      out_mean         <= mean_r;
      out_std_dev      <= sq_res_r[SAMPLE_BITS-1:0];
      out_min_value    <= min_r;
      out_max_value    <= max_r;
      out_has_data     <= (fill_r != '0);
    end
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_C)
    else $error("window fill beyond depth");
  a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (fill_r == DEPTH_C))
    else $error("rescan on a window that is not full");
  a_push_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> push_r)
    else $error("window update without a push command");
  a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && fill_r != '0) |-> (min_r <= max_r))
    else $error("window minimum above maximum");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("result loaded but not presented");
`endif

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sliding window statistics unit: random and
// directed push / add / apply transfers, a behavioral window predictor and a
// field-by-field compare of every result against the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;
  import sws_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int CYCLE_LIMIT = 5000000;
  localparam logic [SAMPLE_BITS-1:0] SMAX = '1;

  typedef struct packed {
    logic [1:0]             op;
    logic [SAMPLE_BITS-1:0] sample;
  } stim_t;

  typedef struct packed {
    logic [CNT_W-1:0]       count;
    logic [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0] sd;
    logic [SAMPLE_BITS-1:0] vmin;
    logic [SAMPLE_BITS-1:0] vmax;
    logic                   has;
  } stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_operation = '0;
  logic [SAMPLE_BITS-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CNT_W-1:0] out_window_count;
  logic [SAMPLE_BITS-1:0] out_mean, out_std_dev, out_min_value, out_max_value;
  logic out_has_data;

  always #HALF_PERIOD clk = ~clk;

  sliding_window_statistics_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_window_count(out_window_count), .out_mean(out_mean),
    .out_std_dev(out_std_dev), .out_min_value(out_min_value),
    .out_max_value(out_max_value), .out_has_data(out_has_data)
  );

  // predictor state: a copy of the window and its running totals
  logic [SAMPLE_BITS-1:0] win [WINDOW_DEPTH];
  int unsigned            win_fill;
  int unsigned            win_head;
  logic [63:0]            win_sum, win_sqsum;
  logic [SAMPLE_BITS-1:0] win_min, win_max;
  logic [SAMPLE_BITS-1:0] pend_total;
  logic                   pend_flag;

  stim_t  pending_items [$];
  stats_t expected_stats [$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     stim_done = 1'b0;
  bit     drain_hold = 1'b0;
  int     hold_off_cycles = 0;
  bit     in_taken = 1'b0;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic window_insert(logic [SAMPLE_BITS-1:0] v);
    logic [SAMPLE_BITS-1:0] old;
    if (win_fill >= WINDOW_DEPTH) begin
      old = win[win_head];
      win[win_head] = v;
      win_head = (win_head + 1) % WINDOW_DEPTH;
      win_sqsum -= 64'(old) * 64'(old);
      win_sum -= 64'(old);
      // evicting an extreme forces a full rescan
      if (old == win_min || old == win_max) begin
        win_min = SMAX;
        win_max = 0;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
          if (win[i] < win_min) win_min = win[i];
          if (win[i] > win_max) win_max = win[i];
        end
      end else begin
        if (v < win_min) win_min = v;
        if (v > win_max) win_max = v;
      end
    end else begin
      win[win_fill] = v;
      win_fill++;
      if (v < win_min) win_min = v;
      if (v > win_max) win_max = v;
    end
    win_sum += 64'(v);
    win_sqsum += 64'(v) * 64'(v);
  endtask

  task automatic predict_stats(stim_t it);
    stats_t s;
    logic [63:0] a, b, n, t;
    case (op_t'(it.op))
      OP_PUSH: window_insert(it.sample);
      OP_ADD: begin
        t = 64'(pend_total) + 64'(it.sample);
        pend_total = (t > 64'(SMAX)) ? SMAX : t[SAMPLE_BITS-1:0];
        pend_flag = 1'b1;
      end
      OP_APPLY: if (pend_flag) begin
        window_insert(pend_total);
        pend_total = '0;
        pend_flag = 1'b0;
      end
      default: ;
    endcase
    n = 64'(win_fill);
    s = '0;
    s.count = CNT_W'(n);
    s.vmin = win_min;
    s.vmax = win_max;
    s.has = (n != 0);
    if (n != 0) begin
      a = n * win_sqsum;
      b = win_sum * win_sum;
      s.mean = SAMPLE_BITS'(win_sum / n);
      s.sd = (a > b) ? SAMPLE_BITS'(int_sqrt((a - b) / (n * n))) : '0;
    end
    expected_stats.push_back(s);
  endtask

  function automatic logic [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SMAX;
      2: return SAMPLE_BITS'($urandom_range(0, 15));
      3: return SAMPLE_BITS'(32'(SMAX) - $urandom_range(0, 15));
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  // input transfer seen at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // driver: offers the queue head, inputs change on the falling edge
  int drv_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        // item taken at the last rising edge
        predict_stats(pending_items.pop_front());
        drv_gap = gap_len();
      end
      if (!in_valid || in_taken) begin
        if (drv_gap > 0 || drain_hold || pending_items.size() == 0) begin
          if (drv_gap > 0) drv_gap--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_operation <= pending_items[0].op;
          in_sample <= pending_items[0].sample;
        end
      end
    end
  end

  // receiver stall: random gaps plus one long hold-off
  int stall_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        stall_left = gap_len();
        out_stall <= (stall_left > 0);
      end
    end
  end

  // monitor: compares each result transfer with the oldest prediction
  always @(posedge clk) begin
    stats_t got, exp_s;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_window_count, out_mean, out_std_dev, out_min_value,
             out_max_value, out_has_data};
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        exp_s = expected_stats.pop_front();
        if (got !== exp_s) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_s, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic bit all_idle();
    return pending_items.size() == 0 && !in_valid && expected_stats.size() == 0;
  endfunction

  initial begin
    win_fill = 0; win_head = 0; win_sum = 0; win_sqsum = 0;
    win_min = SMAX; win_max = 0; pend_total = 0; pend_flag = 0;
    foreach (win[i]) win[i] = '0;

    // directed: empty window, unused code, apply with nothing pending,
    // pending saturation, field extremes
    pending_items.push_back('{OP_NONE, 24'h000001});
    pending_items.push_back('{OP_APPLY, SMAX});
    pending_items.push_back('{OP_PUSH, 24'h0});
    pending_items.push_back('{OP_PUSH, SMAX});
    pending_items.push_back('{OP_ADD, SMAX});
    pending_items.push_back('{OP_ADD, 24'h000005});
    pending_items.push_back('{OP_APPLY, 24'h0});
    pending_items.push_back('{OP_APPLY, 24'h0});
    pending_items.push_back('{OP_ADD, 24'h000003});
    pending_items.push_back('{OP_ADD, 24'h000004});
    pending_items.push_back('{OP_APPLY, SMAX});
    pending_items.push_back('{OP_ADD, 24'h0});
    pending_items.push_back('{OP_APPLY, 24'h0});
    pending_items.push_back('{OP_NONE, SMAX});
    pending_items.push_back('{OP_PUSH, 24'hAAAAAA});
    pending_items.push_back('{OP_PUSH, 24'h555555});

    repeat (6) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // long receiver hold-off while the sender keeps offering
    hold_off_cycles = 3000;
    for (int i = 0; i < 30; i++)
      pending_items.push_back('{OP_PUSH, rand_sample()});

    for (int i = 0; i < 1500; i++) begin
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)      pending_items.push_back('{OP_PUSH, rand_sample()});
      else if (r < 80) pending_items.push_back('{OP_ADD, rand_sample()});
      else if (r < 95) pending_items.push_back('{OP_APPLY, rand_sample()});
      else             pending_items.push_back('{OP_NONE, rand_sample()});
      // sender pause until every result has come
      if (i == 700) begin
        while (!all_idle()) @(posedge clk);
        drain_hold = 1'b1;
        repeat (50) @(posedge clk);
        drain_hold = 1'b0;
      end
    end

    while (!all_idle()) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_stats.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
